/* rtl/nwp_pkg.sv */
// Package for the nearest waypoint window block: field widths, codes, item types.
// No dependencies; used by the top level and by the channels that carry its items.
package nwp_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int IDX_OUT_W      = 10;
  localparam int CNT_OUT_W      = 11;
  localparam int PI_Q           = 25736;
  localparam int TWO_PI_Q       = 51472;
  localparam logic [47:0] COST_CAP = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_INVERTED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_WEIGHT_X       = 3'd0,
    CFG_WEIGHT_Y       = 3'd1,
    CFG_WEIGHT_Z       = 3'd2,
    CFG_WEIGHT_HEADING = 3'd3,
    CFG_AHEAD_LENGTH   = 3'd4,
    CFG_BEHIND_LENGTH  = 3'd5,
    CFG_CLOSED_LOOP    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic        [1:0]  op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] heading;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [IDX_OUT_W-1:0] nearest_index;
    logic [IDX_OUT_W-1:0] start_index;
    logic [IDX_OUT_W-1:0] end_index;
    logic                 wrapped;
    logic [CNT_OUT_W-1:0] window_count;
    logic [47:0]          least_cost;
    logic                 overflow_seen;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] heading;
  } point_t;

endpackage

/* rtl/nwp_stream_if.sv */
// Valid/ready channel with a typed payload, used for input, result and config.
// Payload type comes from nwp_pkg at the point of instantiation.
interface nwp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/nearest_waypoint_window.sv */
// Nearest waypoint window: path store, nearest-point cost scan and window search.
// Depends on nwp_pkg and nwp_stream_if.
//
// The block takes one input transaction at a time. A clear, a dropped load
// (path full) and the first load after a clear are done in the idle state;
// any other load also computes the step length with a one-bit-per-cycle
// square root. For a query, one point-memory read per cycle feeds a
// six-stage cost pipeline, then one length-memory read per cycle feeds the
// window search. An empty-path query goes straight to the output stage. A
// finished result waits in the output register while the next transaction is
// taken. Path memories need no clearing after reset.
module nearest_waypoint_window #(
  parameter int MAX_POINTS = nwp_pkg::MAX_POINTS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  nwp_stream_if.sink   cfg_i,
  nwp_stream_if.sink   in_i,
  nwp_stream_if.source out_o
);

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int CW     = CNT_W + 1;
  localparam int IDX_OW = nwp_pkg::IDX_OUT_W;
  localparam int CNT_OW = nwp_pkg::CNT_OUT_W;
  localparam logic signed [17:0] PI_S     = 18'(nwp_pkg::PI_Q);
  localparam logic signed [17:0] TWO_PI_S = 18'(nwp_pkg::TWO_PI_Q);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LDA, ST_LDW, ST_SQRT, ST_LWR, ST_SCAN,
    ST_NL, ST_SETUP, ST_LSCAN, ST_FIN, ST_DONE
  } state_e;

  function automatic logic [31:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    abs_diff = d[32] ? 32'(-d) : d[31:0];
  endfunction

  function automatic logic [47:0] pos_term(logic [47:0] hi, logic [47:0] lo);
    logic [48:0] t;
    t = {1'b0, hi[23:0], 24'd0} + 49'(lo[47:8]);
    if (hi[47:24] != 24'd0 || t[48]) begin
      pos_term = nwp_pkg::COST_CAP;
    end else begin
      pos_term = t[47:0];
    end
  endfunction

  // configuration
  logic [15:0] wx_q, wy_q, wz_q, wh_q;
  logic [31:0] ah_q, bh_q;
  logic        cl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wx_q <= 16'd256;
      wy_q <= 16'd256;
      wz_q <= 16'd128;
      wh_q <= 16'd51;
      ah_q <= 32'd5120;
      bh_q <= 32'd1280;
      cl_q <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        nwp_pkg::CFG_WEIGHT_X:       wx_q <= cfg_i.data.data[15:0];
        nwp_pkg::CFG_WEIGHT_Y:       wy_q <= cfg_i.data.data[15:0];
        nwp_pkg::CFG_WEIGHT_Z:       wz_q <= cfg_i.data.data[15:0];
        nwp_pkg::CFG_WEIGHT_HEADING: wh_q <= cfg_i.data.data[15:0];
        nwp_pkg::CFG_AHEAD_LENGTH:   ah_q <= cfg_i.data.data;
        nwp_pkg::CFG_BEHIND_LENGTH:  bh_q <= cfg_i.data.data;
        nwp_pkg::CFG_CLOSED_LOOP:    cl_q <= cfg_i.data.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // control
  state_e             state_q;
  logic [CNT_W-1:0]   count_q, issue_q, lissue_q;
  logic               ovf_q;
  logic               out_valid_q;
  nwp_pkg::out_item_t out_q, res_q, fin_res;

  logic in_fire, full, ld_ok;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign full       = (count_q == CNT_W'(MAX_POINTS));
  assign ld_ok      = in_fire && (in_i.data.op == nwp_pkg::OP_LOAD) && !full;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // memories
  nwp_pkg::point_t pt_mem [MAX_POINTS];
  logic [31:0]     len_mem [MAX_POINTS];
  nwp_pkg::point_t pt_wdata, pt_rd_q, in_pt_q, prev_q;
  logic [31:0]     len_rd_q, len_wdata, prev_len_q, len_new;
  logic            len_we;
  logic [IDX_W-1:0] len_raddr, best_q;

  assign pt_wdata = '{pos_x: in_i.data.pos_x, pos_y: in_i.data.pos_y,
                      pos_z: in_i.data.pos_z, heading: in_i.data.heading};

  always_ff @(posedge clk_i) begin
    if (ld_ok) begin
      pt_mem[IDX_W'(count_q)] <= pt_wdata;
    end
    pt_rd_q <= pt_mem[IDX_W'(issue_q)];
  end

  assign len_we    = (ld_ok && count_q == '0) || (state_q == ST_LWR);
  assign len_wdata = (state_q == ST_LWR) ? len_new : 32'd0;
  assign len_raddr = (state_q == ST_NL) ? best_q : IDX_W'(lissue_q);

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[IDX_W'(count_q)] <= len_wdata;
    end
    len_rd_q <= len_mem[len_raddr];
  end

  // cost pipeline; stage A and B also serve the load step length
  logic             rd_v_q, a_v_q, b_v_q, c_v_q, d_v_q, e_v_q, f_v_q;
  logic [IDX_W-1:0] rd_idx_q, a_idx_q, b_idx_q, c_idx_q, d_idx_q, e_idx_q, f_idx_q;
  nwp_pkg::point_t  a_src, b_src;
  logic signed [17:0] he, hw;
  logic [31:0] dx_q, dy_q, dz_q;
  logic [14:0] ae_q;
  logic [63:0] sqx_q, sqy_q, sqz_q;
  logic [29:0] sqh_q;
  logic [47:0] hix_q, lox_q, hiy_q, loy_q, hiz_q, loz_q;
  logic [45:0] hp_q;
  logic [47:0] tx_q, ty_q, tz_q;
  logic [27:0] th_q;
  logic [48:0] sxy_q, szh_q;
  logic [49:0] tot;
  logic [47:0] f_cost_q, best_cost_q;
  logic        scan_go, c_go;

  assign scan_go = (state_q == ST_SCAN) && (issue_q != count_q);
  assign c_go    = b_v_q && (state_q == ST_SCAN);
  assign a_src   = (state_q == ST_LDA) ? in_pt_q : pt_rd_q;
  assign b_src   = (state_q == ST_LDA) ? prev_q : in_pt_q;

  always_comb begin
    he = 18'(a_src.heading) - 18'(b_src.heading);
    if (he > PI_S) begin
      hw = he - TWO_PI_S;
    end else if (he <= -PI_S) begin
      hw = he + TWO_PI_S;
    end else begin
      hw = he;
    end
  end

  assign tot = 50'(sxy_q) + 50'(szh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      c_v_q  <= 1'b0;
      d_v_q  <= 1'b0;
      e_v_q  <= 1'b0;
      f_v_q  <= 1'b0;
    end else begin
      rd_v_q <= scan_go;
      a_v_q  <= rd_v_q || (state_q == ST_LDA);
      b_v_q  <= a_v_q;
      c_v_q  <= c_go;
      d_v_q  <= c_v_q;
      e_v_q  <= d_v_q;
      f_v_q  <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= IDX_W'(issue_q);
    a_idx_q  <= rd_idx_q;
    dx_q     <= abs_diff(a_src.pos_x, b_src.pos_x);
    dy_q     <= abs_diff(a_src.pos_y, b_src.pos_y);
    dz_q     <= abs_diff(a_src.pos_z, b_src.pos_z);
    ae_q     <= hw[17] ? 15'(-hw) : hw[14:0];
    b_idx_q  <= a_idx_q;
    sqx_q    <= dx_q * dx_q;
    sqy_q    <= dy_q * dy_q;
    sqz_q    <= dz_q * dz_q;
    sqh_q    <= ae_q * ae_q;
    c_idx_q  <= b_idx_q;
    hix_q    <= wx_q * sqx_q[63:32];
    lox_q    <= wx_q * sqx_q[31:0];
    hiy_q    <= wy_q * sqy_q[63:32];
    loy_q    <= wy_q * sqy_q[31:0];
    hiz_q    <= wz_q * sqz_q[63:32];
    loz_q    <= wz_q * sqz_q[31:0];
    hp_q     <= wh_q * sqh_q;
    d_idx_q  <= c_idx_q;
    tx_q     <= pos_term(hix_q, lox_q);
    ty_q     <= pos_term(hiy_q, loy_q);
    tz_q     <= pos_term(hiz_q, loz_q);
    th_q     <= hp_q[45:18];
    e_idx_q  <= d_idx_q;
    sxy_q    <= 49'(tx_q) + 49'(ty_q);
    szh_q    <= 49'(tz_q) + 49'(th_q);
    f_idx_q  <= e_idx_q;
    f_cost_q <= (tot > 50'(nwp_pkg::COST_CAP)) ? nwp_pkg::COST_CAP : tot[47:0];
    if (f_v_q && (f_idx_q == '0 || f_cost_q < best_cost_q)) begin
      best_q      <= f_idx_q;
      best_cost_q <= f_cost_q;
    end
  end

  // step length: saturated sum of squares, then square root
  logic [65:0] ssum;
  logic [63:0] sq_v_q, sq_res_q, sq_bt_q, sq_v_n, sq_res_n;
  logic [64:0] sq_trial;
  logic [32:0] len_sum;

  assign ssum = 66'(sqx_q) + 66'(sqy_q) + 66'(sqz_q);

  always_comb begin
    sq_trial = {1'b0, sq_res_q} + {1'b0, sq_bt_q};
    if ({1'b0, sq_v_q} >= sq_trial) begin
      sq_v_n   = sq_v_q - sq_trial[63:0];
      sq_res_n = (sq_res_q >> 1) + sq_bt_q;
    end else begin
      sq_v_n   = sq_v_q;
      sq_res_n = sq_res_q >> 1;
    end
  end

  assign len_sum = 33'(prev_len_q) + 33'(sq_res_q[31:0]);
  assign len_new = len_sum[32] ? 32'hFFFF_FFFF : len_sum[31:0];

  // window search
  logic               lr_v_q;
  logic [IDX_W-1:0]   lr_idx_q, s_q, e_q;
  logic               s_hit_q, e_hit_q, wrap_q;
  logic signed [34:0] sd, ed, tot_len, sd_q, ed_q, lv;
  logic               closed;
  logic               scan_last, ls_last;

  assign sd      = $signed({3'b000, len_rd_q}) - $signed({3'b000, bh_q});
  assign ed      = $signed({3'b000, len_rd_q}) + $signed({3'b000, ah_q});
  assign tot_len = $signed({3'b000, prev_len_q});
  assign closed  = cl_q && (sd < 0 || ed > tot_len);
  assign lv      = $signed({3'b000, len_rd_q});

  assign scan_last = f_v_q && (CNT_W'(f_idx_q) == count_q - 1'b1);
  assign ls_last   = lr_v_q && (CNT_W'(lr_idx_q) == count_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_v_q <= 1'b0;
    end else begin
      lr_v_q <= (state_q == ST_LSCAN) && (lissue_q != count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    lr_idx_q <= IDX_W'(lissue_q);
    if (in_fire) begin
      in_pt_q <= pt_wdata;
    end
    if (ld_ok && count_q == '0) begin
      prev_q     <= pt_wdata;
      prev_len_q <= 32'd0;
    end else if (state_q == ST_LWR) begin
      prev_q     <= in_pt_q;
      prev_len_q <= len_new;
    end
    if (state_q == ST_LDW && b_v_q) begin
      sq_v_q   <= (ssum[65:64] != 2'b00) ? 64'hFFFF_FFFF_FFFF_FFFF : ssum[63:0];
      sq_res_q <= 64'd0;
      sq_bt_q  <= 64'd1 << 62;
    end else if (state_q == ST_SQRT) begin
      sq_v_q   <= sq_v_n;
      sq_res_q <= sq_res_n;
      sq_bt_q  <= sq_bt_q >> 2;
    end
    if (state_q == ST_SETUP) begin
      sd_q    <= (closed && sd < 0) ? sd + tot_len : sd;
      ed_q    <= (closed && ed > tot_len) ? ed - tot_len : ed;
      wrap_q  <= closed;
      s_q     <= closed ? IDX_W'(count_q - 1'b1) : '0;
      e_q     <= closed ? '0 : IDX_W'(count_q - 1'b1);
      s_hit_q <= 1'b0;
      e_hit_q <= 1'b0;
    end else if (lr_v_q) begin
      if (wrap_q) begin
        if (lr_idx_q != '0 && lv <= sd_q) begin
          s_q <= lr_idx_q;
        end
        if (!e_hit_q && lv >= ed_q) begin
          e_q     <= lr_idx_q;
          e_hit_q <= 1'b1;
        end
      end else begin
        if (!s_hit_q && lv >= sd_q) begin
          s_q     <= lr_idx_q;
          s_hit_q <= 1'b1;
        end
        if (lr_idx_q != '0 && lv <= ed_q) begin
          e_q <= lr_idx_q;
        end
      end
    end
  end

  // final result
  logic [CW-1:0]    fin_cnt;
  logic [IDX_W-1:0] fin_s, fin_e;
  logic [1:0]       fin_status;

  always_comb begin
    fin_s      = s_q;
    fin_e      = e_q;
    fin_status = nwp_pkg::STATUS_OK;
    if (wrap_q) begin
      fin_cnt = CW'(count_q) - CW'(s_q) + CW'(e_q) + CW'(1);
    end else if (s_q > e_q) begin
      fin_s      = best_q;
      fin_e      = best_q;
      fin_status = nwp_pkg::STATUS_INVERTED;
      fin_cnt    = CW'(1);
    end else begin
      fin_cnt = CW'(e_q) - CW'(s_q) + CW'(1);
    end
    fin_res = '{status:        fin_status,
                nearest_index: IDX_OW'(best_q),
                start_index:   IDX_OW'(fin_s),
                end_index:     IDX_OW'(fin_e),
                wrapped:       wrap_q,
                window_count:  CNT_OW'(fin_cnt),
                least_cost:    best_cost_q,
                overflow_seen: ovf_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      issue_q     <= '0;
      lissue_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      res_q       <= '0;
    end else begin
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_i.data.op)
              nwp_pkg::OP_CLEAR: begin
                count_q <= '0;
                ovf_q   <= 1'b0;
              end
              nwp_pkg::OP_LOAD: begin
                if (full) begin
                  ovf_q <= 1'b1;
                end else if (count_q == '0) begin
                  count_q <= CNT_W'(1);
                end else begin
                  state_q <= ST_LDA;
                end
              end
              nwp_pkg::OP_QUERY: begin
                if (count_q == '0) begin
                  res_q   <= '{status: nwp_pkg::STATUS_EMPTY, overflow_seen: ovf_q,
                               default: '0};
                  state_q <= ST_DONE;
                end else begin
                  issue_q <= '0;
                  state_q <= ST_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_LDA: state_q <= ST_LDW;
        ST_LDW: begin
          if (b_v_q) begin
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_bt_q[0]) begin
            state_q <= ST_LWR;
          end
        end
        ST_LWR: begin
          count_q <= count_q + 1'b1;
          state_q <= ST_IDLE;
        end
        ST_SCAN: begin
          if (issue_q != count_q) begin
            issue_q <= issue_q + 1'b1;
          end
          if (scan_last) begin
            state_q <= ST_NL;
          end
        end
        ST_NL: state_q <= ST_SETUP;
        ST_SETUP: begin
          lissue_q <= '0;
          state_q  <= ST_LSCAN;
        end
        ST_LSCAN: begin
          if (lissue_q != count_q) begin
            lissue_q <= lissue_q + 1'b1;
          end
          if (ls_last) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          res_q   <= fin_res;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_sqrt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LWR |-> $past(sq_bt_q) == 64'd1)
    else $error("step length written before square root finished");

  a_cost_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_v_q |-> state_q == ST_SCAN)
    else $error("cost pipeline active outside the scan");

endmodule

/* tb/nearest_waypoint_window_tb.sv */
// Testbench for nearest_waypoint_window: directed and random path loads, clears and queries
// against a local predictor of the cost scan and window search, with random stalls on the input and output sides.
// Depends on nwp_pkg and nwp_stream_if from the RTL.
module nearest_waypoint_window_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nwp_pkg::*;

  localparam int DEPTH = MAX_POINTS_DEF;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT = 40000;

  logic clk_i;
  logic rst_ni;

  nwp_stream_if #(.T(cfg_item_t)) cfg_if ();
  nwp_stream_if #(.T(in_item_t))  in_if ();
  nwp_stream_if #(.T(out_item_t)) out_if ();

  nearest_waypoint_window DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  logic signed [31:0] path_east [DEPTH];
  logic signed [31:0] path_north [DEPTH];
  logic signed [31:0] path_up [DEPTH];
  logic signed [15:0] path_heading [DEPTH];
  logic [31:0]        path_length [DEPTH];
  int                 path_size;
  logic               full_dropped;

  logic [15:0] w_east, w_north, w_up, w_head;
  logic [31:0] len_ahead, len_behind;
  logic        loop_mode;

  out_item_t window_queue[$];
  int        mismatches;
  int        stall_cycles;
  int        results_seen;
  int        loads_sent;
  int        queries_sent;
  int        cfg_writes;
  bit        no_idle;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
    longint da, db;
    da = a;
    db = b;
    return (da >= db) ? 64'(da - db) : 64'(db - da);
  endfunction

  function automatic logic [47:0] sat_cost(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, COST_CAP}) ? COST_CAP : s[47:0];
  endfunction

  function automatic logic [47:0] axis_term(logic [15:0] w, logic [63:0] sq);
    logic [79:0] p;
    p = ({64'd0, w} * {16'd0, sq}) >> 8;
    return (p > {32'd0, COST_CAP}) ? COST_CAP : p[47:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [47:0] pose_cost(int i, in_item_t q);
    longint      e;
    logic [63:0] dx, dy, dz, ae;
    logic [47:0] c;
    dx = abs_diff(path_east[i], q.pos_x);
    dy = abs_diff(path_north[i], q.pos_y);
    dz = abs_diff(path_up[i], q.pos_z);
    e = longint'(path_heading[i]) - longint'(q.heading);
    while (e > PI_Q) e = e - TWO_PI_Q;
    while (e <= -PI_Q) e = e + TWO_PI_Q;
    ae = (e < 0) ? 64'(-e) : 64'(e);
    c = axis_term(w_east, dx * dx);
    c = sat_cost(c, axis_term(w_north, dy * dy));
    c = sat_cost(c, axis_term(w_up, dz * dz));
    c = sat_cost(c, 48'(({48'd0, w_head} * ae * ae) >> 18));
    return c;
  endfunction

  function automatic void store_waypoint(in_item_t p);
    logic [64:0] sq;
    logic [63:0] dx, dy, dz;
    logic [33:0] len;
    int          n;
    n = path_size;
    if (n >= DEPTH) begin
      full_dropped = 1'b1;
      return;
    end
    path_east[n] = p.pos_x;
    path_north[n] = p.pos_y;
    path_up[n] = p.pos_z;
    path_heading[n] = p.heading;
    len = 0;
    if (n > 0) begin
      dx = abs_diff(p.pos_x, path_east[n-1]);
      dy = abs_diff(p.pos_y, path_north[n-1]);
      dz = abs_diff(p.pos_z, path_up[n-1]);
      sq = {1'b0, dx * dx} + {1'b0, dy * dy};
      if (sq[64]) sq = {1'b0, {64{1'b1}}};
      sq = sq + {1'b0, dz * dz};
      if (sq[64]) sq = {1'b0, {64{1'b1}}};
      len = {2'b0, path_length[n-1]} + {2'b0, floor_sqrt(sq[63:0])};
      if (len > 34'hFFFF_FFFF) len = 34'hFFFF_FFFF;
    end
    path_length[n] = len[31:0];
    path_size = n + 1;
  endfunction

  function automatic out_item_t predict_window(in_item_t q);
    out_item_t   r;
    logic [47:0] best_cost, c;
    longint      nl, sd, ed, total;
    int          n, best, s, e, count;
    r = '0;
    r.overflow_seen = full_dropped;
    n = path_size;
    if (n == 0) begin
      r.status = STATUS_EMPTY;
      return r;
    end
    best = 0;
    best_cost = pose_cost(0, q);
    for (int i = 1; i < n; i++) begin
      c = pose_cost(i, q);
      if (c < best_cost) begin
        best_cost = c;
        best = i;
      end
    end
    nl = longint'(path_length[best]);
    sd = nl - longint'(len_behind);
    ed = nl + longint'(len_ahead);
    total = longint'(path_length[n-1]);
    r.status = STATUS_OK;
    if (loop_mode && (sd < 0 || ed > total)) begin
      if (sd < 0) sd = sd + total;
      if (ed > total) ed = ed - total;
      s = n - 1;
      for (int i = n - 1; i > 0; i--) begin
        if (longint'(path_length[i]) <= sd) begin
          s = i;
          break;
        end
      end
      e = 0;
      for (int i = 0; i < n; i++) begin
        if (longint'(path_length[i]) >= ed) begin
          e = i;
          break;
        end
      end
      r.wrapped = 1'b1;
      count = (n - s) + e + 1;
    end else begin
      s = 0;
      for (int i = 0; i < n; i++) begin
        if (longint'(path_length[i]) >= sd) begin
          s = i;
          break;
        end
      end
      e = n - 1;
      for (int i = n - 1; i > 0; i--) begin
        if (longint'(path_length[i]) <= ed) begin
          e = i;
          break;
        end
      end
      if (s > e) begin
        r.status = STATUS_INVERTED;
        s = best;
        e = best;
      end
      count = e - s + 1;
    end
    r.nearest_index = best[IDX_OUT_W-1:0];
    r.start_index = s[IDX_OUT_W-1:0];
    r.end_index = e[IDX_OUT_W-1:0];
    r.window_count = count[CNT_OUT_W-1:0];
    r.least_cost = best_cost;
    return r;
  endfunction

  function automatic void apply_register(cfg_idx_e idx, logic [31:0] v);
    case (idx)
      CFG_WEIGHT_X:       w_east = v[15:0];
      CFG_WEIGHT_Y:       w_north = v[15:0];
      CFG_WEIGHT_Z:       w_up = v[15:0];
      CFG_WEIGHT_HEADING: w_head = v[15:0];
      CFG_AHEAD_LENGTH:   len_ahead = v;
      CFG_BEHIND_LENGTH:  len_behind = v;
      CFG_CLOSED_LOOP:    loop_mode = v[0];
      default: ;
    endcase
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic send_item(op_e op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [15:0] h);
    in_item_t it;
    int       gap;
    it.op = op;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.heading = h;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    case (op)
      OP_CLEAR: begin
        path_size = 0;
        full_dropped = 1'b0;
      end
      OP_LOAD: begin
        store_waypoint(it);
        loads_sent++;
      end
      OP_QUERY: begin
        window_queue.push_back(predict_window(it));
        queries_sent++;
      end
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (window_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [31:0] v);
    cfg_item_t c;
    c.index = idx;
    c.data = v;
    cfg_if.valid <= 1'b1;
    cfg_if.data <= c;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    apply_register(idx, v);
    cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic program_window(logic [15:0] wx, logic [15:0] wy, logic [15:0] wz,
                                logic [15:0] wh, logic [31:0] ahead, logic [31:0] behind,
                                logic closed);
    drain_results();
    write_register(CFG_WEIGHT_X, {16'd0, wx});
    write_register(CFG_WEIGHT_Y, {16'd0, wy});
    write_register(CFG_WEIGHT_Z, {16'd0, wz});
    write_register(CFG_WEIGHT_HEADING, {16'd0, wh});
    write_register(CFG_AHEAD_LENGTH, ahead);
    write_register(CFG_BEHIND_LENGTH, behind);
    write_register(CFG_CLOSED_LOOP, {31'd0, closed});
  endtask

  function automatic logic [15:0] rand_heading();
    return 16'($urandom_range(0, 2 * PI_Q) - PI_Q);
  endfunction

  task automatic query_near(int span);
    int k;
    if (path_size == 0) begin
      send_item(OP_QUERY, $urandom, $urandom, $urandom, rand_heading());
      return;
    end
    k = $urandom_range(0, path_size - 1);
    send_item(OP_QUERY, path_east[k] + $urandom_range(0, 2 * span) - span,
              path_north[k] + $urandom_range(0, 2 * span) - span,
              path_up[k] + $urandom_range(0, span) - span / 2, rand_heading());
  endtask

  task automatic load_walk(int count, int step);
    logic [31:0] x, y, z;
    x = $urandom_range(0, 8192) - 4096;
    y = $urandom_range(0, 8192) - 4096;
    z = $urandom_range(0, 512) - 256;
    for (int i = 0; i < count; i++) begin
      send_item(OP_LOAD, x, y, z, rand_heading());
      x = x + $urandom_range(0, 2 * step) - step / 2;
      y = y + $urandom_range(0, 2 * step) - step;
      z = z + $urandom_range(0, step / 4);
    end
  endtask

  task automatic test_empty_and_unused_op();
    send_item(OP_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'(PI_Q));
    send_item(op_e'(2'd3), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(OP_QUERY, 32'd0, 32'd0, 32'd0, 16'(-PI_Q));
  endtask

  task automatic test_extreme_points();
    send_item(OP_CLEAR, 0, 0, 0, 0);
    send_item(OP_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'(-PI_Q));
    send_item(OP_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'(PI_Q));
    send_item(OP_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'(PI_Q));
    send_item(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'd0);
    send_item(OP_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'(-PI_Q));
    send_item(OP_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'(PI_Q));
    send_item(OP_QUERY, 32'h0, 32'h0, 32'h0, 16'h0);
  endtask

  task automatic test_equal_costs();
    send_item(OP_CLEAR, 0, 0, 0, 0);
    send_item(OP_LOAD, 32'd512, 32'd0, 32'd0, 16'd100);
    send_item(OP_LOAD, 32'd0, 32'd0, 32'd0, 16'd0);
    send_item(OP_LOAD, 32'd0, 32'd0, 32'd0, 16'd0);
    send_item(OP_LOAD, -32'sd512, 32'd0, 32'd0, 16'd100);
    send_item(OP_QUERY, 32'd0, 32'd0, 32'd0, 16'd0);
    send_item(OP_QUERY, 32'd0, 32'd1, 32'd0, 16'd50);
  endtask

  task automatic test_window_settings();
    program_window(16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0, 1'b0);
    load_walk(6, 1024);
    query_near(256);
    program_window(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    query_near(256);
    send_item(OP_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'(PI_Q));
    program_window(16'hFFFF, 16'h0001, 16'h0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    query_near(64);
    program_window(16'd256, 16'd256, 16'd128, 16'd51, 32'd700, 32'd900, 1'b1);
    for (int i = 0; i < 3; i++) query_near(512);
  endtask

  task automatic test_full_path();
    no_idle = 1;
    send_item(OP_CLEAR, 0, 0, 0, 0);
    load_walk(DEPTH + 2, 600);
    query_near(100);
    send_item(OP_CLEAR, 0, 0, 0, 0);
    send_item(OP_LOAD, 32'd5, 32'd6, 32'd7, 16'd8);
    query_near(10);
    no_idle = 0;
  endtask

  task automatic test_random_paths();
    int sent, r, pts;
    sent = 0;
    while (sent < 280) begin
      if ($urandom_range(0, 9) == 0) begin
        drain_results();
        program_window($urandom, $urandom, $urandom, $urandom,
                       $urandom_range(0, 6000), $urandom_range(0, 6000), $urandom_range(0, 1));
      end
      no_idle = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      if (r < 8) begin
        pts = $urandom_range(1, 12);
        send_item(OP_CLEAR, 0, 0, 0, 0);
        load_walk(pts, $urandom_range(16, 2048));
        for (int i = 0; i < 3; i++) query_near(1024);
        sent += pts + 4;
      end else if (r == 8) begin
        send_item(OP_LOAD, $urandom, $urandom, $urandom, rand_heading());
        send_item(OP_QUERY, $urandom, $urandom, $urandom, rand_heading());
        send_item(op_e'(2'd3), $urandom, $urandom, $urandom, $urandom);
        sent += 2;
      end else begin
        send_item(OP_CLEAR, 0, 0, 0, 0);
        send_item(OP_QUERY, $urandom, $urandom, $urandom, rand_heading());
        sent += 2;
      end
    end
    no_idle = 0;
  endtask

  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  always @(posedge clk_i) begin
    out_item_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      results_seen++;
      if (window_queue.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        want = window_queue.pop_front();
        if (got.status !== want.status) begin
          $display("%0t status: expected %0d, actual %0d", $time, want.status, got.status);
          mismatches++;
        end
        if (got.nearest_index !== want.nearest_index) begin
          $display("%0t nearest_index: expected %0d, actual %0d", $time,
                   want.nearest_index, got.nearest_index);
          mismatches++;
        end
        if (got.start_index !== want.start_index) begin
          $display("%0t start_index: expected %0d, actual %0d", $time,
                   want.start_index, got.start_index);
          mismatches++;
        end
        if (got.end_index !== want.end_index) begin
          $display("%0t end_index: expected %0d, actual %0d", $time,
                   want.end_index, got.end_index);
          mismatches++;
        end
        if (got.wrapped !== want.wrapped) begin
          $display("%0t wrapped: expected %0d, actual %0d", $time, want.wrapped, got.wrapped);
          mismatches++;
        end
        if (got.window_count !== want.window_count) begin
          $display("%0t window_count: expected %0d, actual %0d", $time,
                   want.window_count, got.window_count);
          mismatches++;
        end
        if (got.least_cost !== want.least_cost) begin
          $display("%0t least_cost: expected %h, actual %h", $time,
                   want.least_cost, got.least_cost);
          mismatches++;
        end
        if (got.overflow_seen !== want.overflow_seen) begin
          $display("%0t overflow_seen: expected %0d, actual %0d", $time,
                   want.overflow_seen, got.overflow_seen);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, stall_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    stall_cycles = 0;
    results_seen = 0;
    loads_sent = 0;
    queries_sent = 0;
    cfg_writes = 0;
    no_idle = 0;
    path_size = 0;
    full_dropped = 1'b0;
    w_east = 16'd256;
    w_north = 16'd256;
    w_up = 16'd128;
    w_head = 16'd51;
    len_ahead = 32'd5120;
    len_behind = 32'd1280;
    loop_mode = 1'b1;
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_unused_op();
    test_extreme_points();
    test_equal_costs();
    test_window_settings();
    test_full_path();
    test_random_paths();

    drain_results();
    $display("covered %0d loads, %0d queries, %0d register writes, %0d results checked",
             loads_sent, queries_sent, cfg_writes, results_seen);
    $display("paths from empty to full, open and closed-loop windows, saturating costs");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/nwp_pkg.sv
rtl/nwp_stream_if.sv
rtl/nearest_waypoint_window.sv
tb/nearest_waypoint_window_tb.sv
